FILE: rtl/ntsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsu_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ntsu_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int FILL_W     = IDX_W + 1;
   localparam int STAMP_W    = 32;
   localparam int LOCAL_W    = 48;
   localparam int CFG_W      = 16;
   localparam int CMD_W      = 2;
   localparam int ACT_W      = 3;
   localparam int CSR_IDX_W  = 1;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

   localparam logic [CFG_W-1:0] NUDGE_RESET  = CFG_W'(100);
   localparam logic [CFG_W-1:0] RESYNC_RESET = CFG_W'(300);

   // us -> ms divider: 48-bit value split in 16-bit chunks, the residue sum is
   // divided by a reciprocal multiply (exact for sums below 2^26)
   localparam int DIV_STEPS   = 3;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int SUM_W       = 26;
   localparam int RECIP_W     = 27;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int RECIP_SHIFT = 36;
   localparam int PART_W      = PROD_W - RECIP_SHIFT;

   localparam logic [SUM_W-1:0]   US_PER_MS = SUM_W'(1000);
   localparam logic [SUM_W-1:0]   MOD_2P32  = SUM_W'(296);
   localparam logic [SUM_W-1:0]   MOD_2P16  = SUM_W'(536);
   localparam logic [STAMP_W-1:0] QUO_2P32  = STAMP_W'(4294967);
   localparam logic [STAMP_W-1:0] QUO_2P16  = STAMP_W'(65);
   localparam logic [RECIP_W-1:0] MS_RECIP  = RECIP_W'(68719477);

   localparam logic [DIV_CNT_W-1:0] DIV_ST_SPLIT = DIV_CNT_W'(3);
   localparam logic [DIV_CNT_W-1:0] DIV_ST_MUL   = DIV_CNT_W'(2);
   localparam logic [DIV_CNT_W-1:0] DIV_ST_FIX   = DIV_CNT_W'(1);

   localparam logic [CMD_W-1:0] CMD_RECORD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FIRST   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DOWN    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_UP      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_IN_BAND = 3'd4;
   localparam logic [ACT_W-1:0] ACT_RESYNC  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUDGE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC = 1'd1;

   typedef struct packed {
      logic load;
      logic rec_write;
      logic clear;
      logic walk_start;
      logic walk_step;
      logic walk_gt;
      logic walk_hit;
      logic first_sync;
      logic div_start;
      logic div_rec;
      logic take_n;
      logic apply;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             walk_end;
      logic             walk_gt;
      logic             walk_eq;
      logic             est_zero;
      logic             div_busy;
      logic             rsp_busy;
   } dp_status_type;

endpackage

FILE: rtl/ntsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsu_ctrl
// Sequencer: dispatches commands, steps the ring walk and the divider runs.
// ----------------------------------------------------------------------------
module ntsu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ntsu_pkg::dp_status_type status,
   output ntsu_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_HIT,
      ST_DIV_N,
      ST_DIV_R,
      ST_DIV_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.cmd)
               ntsu_pkg::CMD_RECORD: begin
                  cmd.rec_write = 1'b1;
                  state_in      = ST_FINISH;
               end
               ntsu_pkg::CMD_RESPONSE: begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_WALK_RD;
               end
               ntsu_pkg::CMD_READ: begin
                  if (status.est_zero) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV_READ;
                  end
               end
               default: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FINISH;
               end
            endcase
         end
         ST_WALK_RD: begin
            // ring read data lands at the end of this cycle
            state_in = status.walk_end ? ST_FINISH : ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            if (status.walk_gt) begin
               cmd.walk_gt = 1'b1;
               state_in    = ST_FINISH;
            end else if (status.walk_eq) begin
               cmd.walk_hit = 1'b1;
               state_in     = ST_HIT;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ST_WALK_RD;
            end
         end
         ST_HIT: begin
            if (status.est_zero) begin
               cmd.first_sync = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_N;
            end
         end
         ST_DIV_N: begin
            if (!status.div_busy) begin
               cmd.take_n    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_rec   = 1'b1;
               state_in      = ST_DIV_R;
            end
         end
         ST_DIV_R: begin
            if (!status.div_busy) begin
               cmd.apply = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_DIV_READ: begin
            if (!status.div_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

FILE: rtl/ntsu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsu_dp
// Datapath: stamp ring, pointers, estimate, us->ms divider, result register.
// ----------------------------------------------------------------------------
module ntsu_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ntsu_pkg::ctrl_cmd_type        cmd,
   output ntsu_pkg::dp_status_type       status,
   input  logic                          csr_wr_en,
   input  logic [ntsu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ntsu_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic [ntsu_pkg::CMD_W-1:0]    req_cmd,
   input  logic [ntsu_pkg::STAMP_W-1:0]  req_net_stamp,
   input  logic [ntsu_pkg::STAMP_W-1:0]  req_path_delay,
   input  logic [ntsu_pkg::STAMP_W-1:0]  req_stay_time,
   input  logic [ntsu_pkg::LOCAL_W-1:0]  req_local_time_us,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ntsu_pkg::STAMP_W-1:0]  rsp_network_time,
   output logic                          rsp_match_found,
   output logic [ntsu_pkg::ACT_W-1:0]    rsp_action,
   output logic                          rsp_synced,
   output logic [ntsu_pkg::FILL_W-1:0]   rsp_ring_fill
);

   localparam int SW  = ntsu_pkg::STAMP_W;
   localparam int LW  = ntsu_pkg::LOCAL_W;
   localparam int IW  = ntsu_pkg::IDX_W;
   localparam int FW  = ntsu_pkg::FILL_W;
   localparam int MW  = ntsu_pkg::SUM_W;
   localparam int PW  = ntsu_pkg::PROD_W;
   localparam int RCW = ntsu_pkg::RECIP_W;
   localparam int QW  = ntsu_pkg::PART_W;

   logic [SW-1:0] ring_stamp [ntsu_pkg::RING_DEPTH];
   logic [LW-1:0] ring_us    [ntsu_pkg::RING_DEPTH];

   logic [ntsu_pkg::CMD_W-1:0] cmd_ff;
   logic [SW-1:0]  stamp_ff, delay_ff, orig_ff;
   logic [LW-1:0]  now_ff;
   logic [SW-1:0]  rd_stamp_ff;
   logic [LW-1:0]  rd_us_ff;
   logic [IW-1:0]  oldest_ff, wr_ff, pos_ff;
   logic [FW-1:0]  fill_ff, cnt_ff;
   logic [SW-1:0]  est_ff, n_ff;
   logic [LW-1:0]  anchor_ff;
   logic [ntsu_pkg::CFG_W-1:0] nudge_ff, resync_ff;
   logic           hit_ff;
   logic [ntsu_pkg::ACT_W-1:0] act_ff;

   logic [LW-1:0]  dv_mag_ff;
   logic           dv_neg_ff;
   logic [MW-1:0]  dv_sum_ff;
   logic [SW-1:0]  dv_hi_ff;
   logic [QW-1:0]  dv_part_ff;
   logic [SW-1:0]  dv_q_ff;
   logic [ntsu_pkg::DIV_CNT_W-1:0] dv_cnt_ff;

   logic           rsp_valid_ff;
   logic [SW-1:0]  rsp_net_ff;
   logic           rsp_match_ff, rsp_synced_ff;
   logic [ntsu_pkg::ACT_W-1:0] rsp_act_ff;
   logic [FW-1:0]  rsp_fill_ff;

   // divider front end and stages
   logic [LW-1:0] dv_src;
   logic [LW:0]   dv_diff, dv_negd;
   logic [MW-1:0] dv_sum, dv_back;
   logic [SW-1:0] dv_hi;
   logic [PW-1:0] dv_prod;
   logic [QW-1:0] dv_part;
   logic          dv_rem_nz;
   logic [SW-1:0] dv_qpos, dv_q;

   assign dv_src    = cmd.div_rec ? rd_us_ff : anchor_ff;
   assign dv_diff   = {1'b0, now_ff} - {1'b0, dv_src};
   assign dv_negd   = ~dv_diff + 1'b1;
   // x = h*2^32 + m*2^16 + l; residue sum keeps x mod 1000
   assign dv_sum    = {{(MW-16){1'b0}}, dv_mag_ff[LW-1:32]} * ntsu_pkg::MOD_2P32
                    + {{(MW-16){1'b0}}, dv_mag_ff[31:16]} * ntsu_pkg::MOD_2P16
                    + {{(MW-16){1'b0}}, dv_mag_ff[15:0]};
   assign dv_hi     = {16'd0, dv_mag_ff[LW-1:32]} * ntsu_pkg::QUO_2P32
                    + {16'd0, dv_mag_ff[31:16]} * ntsu_pkg::QUO_2P16;
   assign dv_prod   = {{(PW-MW){1'b0}}, dv_sum_ff} * {{(PW-RCW){1'b0}}, ntsu_pkg::MS_RECIP};
   assign dv_part   = dv_prod[PW-1:ntsu_pkg::RECIP_SHIFT];
   assign dv_back   = {{(MW-QW){1'b0}}, dv_part_ff} * ntsu_pkg::US_PER_MS;
   assign dv_rem_nz = (dv_back != dv_sum_ff);
   // negative differences round toward minus infinity
   assign dv_qpos   = dv_hi_ff + {{(SW-QW){1'b0}}, dv_part_ff}
                    + {{(SW-1){1'b0}}, dv_neg_ff && dv_rem_nz};
   assign dv_q      = dv_q_ff;

   // compare stage
   logic [SW-1:0] base, r_val, err, mag;
   assign base  = rd_stamp_ff + (delay_ff >> 1);
   assign r_val = base + dv_q;
   assign err   = n_ff - r_val;
   assign mag   = err[SW-1] ? (~err + 1'b1) : err;

   always_ff @(posedge clock) begin
      if (cmd.rec_write) begin
         ring_stamp[wr_ff] <= stamp_ff;
         ring_us[wr_ff]    <= now_ff;
      end
      rd_stamp_ff <= ring_stamp[pos_ff];
      rd_us_ff    <= ring_us[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         stamp_ff <= req_net_stamp;
         delay_ff <= req_path_delay;
         orig_ff  <= req_net_stamp - req_path_delay - req_stay_time;
         now_ff   <= req_local_time_us;
      end
      if (cmd.walk_start)     pos_ff <= oldest_ff;
      else if (cmd.walk_step) pos_ff <= pos_ff + 1'b1;
      if (cmd.walk_start)     cnt_ff <= '0;
      else if (cmd.walk_step) cnt_ff <= cnt_ff + 1'b1;
      if (cmd.take_n) n_ff <= est_ff + dv_q;
      if (cmd.div_start) begin
         dv_neg_ff <= dv_diff[LW];
         dv_mag_ff <= dv_diff[LW] ? dv_negd[LW-1:0] : dv_diff[LW-1:0];
      end
      case (dv_cnt_ff)
         ntsu_pkg::DIV_ST_SPLIT: begin
            dv_sum_ff <= dv_sum;
            dv_hi_ff  <= dv_hi;
         end
         ntsu_pkg::DIV_ST_MUL: dv_part_ff <= dv_part;
         ntsu_pkg::DIV_ST_FIX: dv_q_ff    <= dv_neg_ff ? (~dv_qpos + 1'b1) : dv_qpos;
         default: ;
      endcase
      if (cmd.out_load) begin
         rsp_net_ff    <= (cmd_ff == ntsu_pkg::CMD_READ && est_ff != '0)
                          ? est_ff + dv_q : est_ff;
         rsp_match_ff  <= hit_ff;
         rsp_act_ff    <= act_ff;
         rsp_synced_ff <= (est_ff != '0);
         rsp_fill_ff   <= fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         wr_ff        <= '0;
         fill_ff      <= '0;
         est_ff       <= '0;
         anchor_ff    <= '0;
         nudge_ff     <= ntsu_pkg::NUDGE_RESET;
         resync_ff    <= ntsu_pkg::RESYNC_RESET;
         hit_ff       <= 1'b0;
         act_ff       <= ntsu_pkg::ACT_NONE;
         dv_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ntsu_pkg::CSR_NUDGE:  nudge_ff  <= csr_wr_data;
               ntsu_pkg::CSR_RESYNC: resync_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.load) begin
            hit_ff <= 1'b0;
            act_ff <= ntsu_pkg::ACT_NONE;
         end
         if (cmd.rec_write) begin
            wr_ff <= wr_ff + 1'b1;
            if (fill_ff == ntsu_pkg::FILL_FULL) oldest_ff <= wr_ff + 1'b1;
            else                                fill_ff   <= fill_ff + 1'b1;
         end
         if (cmd.clear) begin
            est_ff    <= '0;
            oldest_ff <= '0;
            wr_ff     <= '0;
            fill_ff   <= '0;
         end
         if (cmd.walk_gt) begin
            fill_ff   <= fill_ff - cnt_ff;
            oldest_ff <= pos_ff;
         end
         if (cmd.walk_hit) begin
            fill_ff   <= fill_ff - cnt_ff - 1'b1;
            oldest_ff <= pos_ff + 1'b1;
            hit_ff    <= 1'b1;
         end
         if (cmd.first_sync) begin
            est_ff    <= base;
            anchor_ff <= rd_us_ff;
            act_ff    <= ntsu_pkg::ACT_FIRST;
         end
         if (cmd.apply) begin
            if (mag >= {{(SW-ntsu_pkg::CFG_W){1'b0}}, resync_ff}) begin
               est_ff    <= base;
               anchor_ff <= rd_us_ff;
               act_ff    <= ntsu_pkg::ACT_RESYNC;
            end else if (mag > {{(SW-ntsu_pkg::CFG_W){1'b0}}, nudge_ff}) begin
               if (n_ff > r_val) begin
                  est_ff <= est_ff - 1'b1;
                  act_ff <= ntsu_pkg::ACT_DOWN;
               end else begin
                  est_ff <= est_ff + 1'b1;
                  act_ff <= ntsu_pkg::ACT_UP;
               end
            end else begin
               act_ff <= ntsu_pkg::ACT_IN_BAND;
            end
         end
         if (cmd.div_start)        dv_cnt_ff <= ntsu_pkg::DIV_CNT_W'(ntsu_pkg::DIV_STEPS);
         else if (dv_cnt_ff != '0) dv_cnt_ff <= dv_cnt_ff - 1'b1;
         if (cmd.out_load)                rsp_valid_ff <= 1'b1;
         else if (rsp_ready)              rsp_valid_ff <= 1'b0;
      end
   end

   assign status.cmd      = cmd_ff;
   assign status.walk_end = (cnt_ff == fill_ff);
   assign status.walk_gt  = (rd_stamp_ff > orig_ff);
   assign status.walk_eq  = (rd_stamp_ff == orig_ff);
   assign status.est_zero = (est_ff == '0);
   assign status.div_busy = (dv_cnt_ff != '0);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_network_time = rsp_net_ff;
   assign rsp_match_found  = rsp_match_ff;
   assign rsp_action       = rsp_act_ff;
   assign rsp_synced       = rsp_synced_ff;
   assign rsp_ring_fill    = rsp_fill_ff;

endmodule

FILE: rtl/network_time_sync_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_time_sync_unit
// Network time estimate kept against a ring of recorded stamps.
// ----------------------------------------------------------------------------
// One item at a time, one result per item. Read runs the 3-stage us-to-ms
// divider when synced. A response walks the ring one entry at a time
// (registered ring read, then compare), and a match while synced adds two
// divider runs. The result sits in an output register, so a new item is
// taken while it waits.
module network_time_sync_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ntsu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ntsu_pkg::CFG_W-1:0]     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ntsu_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ntsu_pkg::STAMP_W-1:0]   req_net_stamp,
   input  logic [ntsu_pkg::STAMP_W-1:0]   req_path_delay,
   input  logic [ntsu_pkg::STAMP_W-1:0]   req_stay_time,
   input  logic [ntsu_pkg::LOCAL_W-1:0]   req_local_time_us,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ntsu_pkg::STAMP_W-1:0]   rsp_network_time,
   output logic                           rsp_match_found,
   output logic [ntsu_pkg::ACT_W-1:0]     rsp_action,
   output logic                           rsp_synced,
   output logic [ntsu_pkg::FILL_W-1:0]    rsp_ring_fill
);

   ntsu_pkg::ctrl_cmd_type  cmd;
   ntsu_pkg::dp_status_type status;

   ntsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ntsu_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_cmd           (req_cmd),
      .req_net_stamp     (req_net_stamp),
      .req_path_delay    (req_path_delay),
      .req_stay_time     (req_stay_time),
      .req_local_time_us (req_local_time_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_network_time  (rsp_network_time),
      .rsp_match_found   (rsp_match_found),
      .rsp_action        (rsp_action),
      .rsp_synced        (rsp_synced),
      .rsp_ring_fill     (rsp_ring_fill)
   );

endmodule

FILE: rtl/ntsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsu_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ntsu_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ntsu_pkg::STAMP_W-1:0] rsp_network_time,
   input logic                         rsp_match_found,
   input logic [ntsu_pkg::ACT_W-1:0]   rsp_action,
   input logic                         rsp_synced,
   input logic [ntsu_pkg::FILL_W-1:0]  rsp_ring_fill
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_network_time))
      else $error("result dropped or changed while stalled");

   a_unsynced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_synced |-> rsp_network_time == '0)
      else $error("unsynced result carries a nonzero time");

   a_action_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_found == (rsp_action != ntsu_pkg::ACT_NONE)))
      else $error("action and match flag disagree");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ring_fill <= ntsu_pkg::FILL_FULL)
      else $error("ring fill above depth");

endmodule

bind network_time_sync_unit ntsu_checker u_ntsu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_network_time (rsp_network_time),
   .rsp_match_found  (rsp_match_found),
   .rsp_action       (rsp_action),
   .rsp_synced       (rsp_synced),
   .rsp_ring_fill    (rsp_ring_fill)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_time_sync_unit testbench
// Drives record, response, read and clear commands with bursty handshakes and
// a stalling receiver. A local time-sync predictor computes every result and
// a scoreboard compares each response transfer field by field. Several
// threshold settings are visited, and a run of records feeds a deep walk.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [ntsu_pkg::CMD_W-1:0]   cmd;
      logic [ntsu_pkg::STAMP_W-1:0] stamp;
      logic [ntsu_pkg::STAMP_W-1:0] delay;
      logic [ntsu_pkg::STAMP_W-1:0] stay;
      logic [ntsu_pkg::LOCAL_W-1:0] now;
   } sync_cmd_type;

   typedef struct {
      logic [ntsu_pkg::STAMP_W-1:0] net_time;
      logic                         match;
      logic [ntsu_pkg::ACT_W-1:0]   action;
      logic                         synced;
      logic [ntsu_pkg::FILL_W-1:0]  fill;
   } sync_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [ntsu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ntsu_pkg::CFG_W-1:0]     csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [ntsu_pkg::CMD_W-1:0]     req_cmd = '0;
   logic [ntsu_pkg::STAMP_W-1:0]   req_net_stamp = '0;
   logic [ntsu_pkg::STAMP_W-1:0]   req_path_delay = '0;
   logic [ntsu_pkg::STAMP_W-1:0]   req_stay_time = '0;
   logic [ntsu_pkg::LOCAL_W-1:0]   req_local_time_us = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [ntsu_pkg::STAMP_W-1:0]   rsp_network_time;
   logic                           rsp_match_found;
   logic [ntsu_pkg::ACT_W-1:0]     rsp_action;
   logic                           rsp_synced;
   logic [ntsu_pkg::FILL_W-1:0]    rsp_ring_fill;

   network_time_sync_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [ntsu_pkg::STAMP_W-1:0] ring_st [ntsu_pkg::RING_DEPTH];
   logic [ntsu_pkg::LOCAL_W-1:0] ring_us [ntsu_pkg::RING_DEPTH];
   int unsigned                  ring_head, ring_tail, ring_cnt;
   logic [ntsu_pkg::STAMP_W-1:0] est_ms;
   logic [ntsu_pkg::LOCAL_W-1:0] anchor_us;
   logic [ntsu_pkg::CFG_W-1:0]   nudge_ms = ntsu_pkg::NUDGE_RESET;
   logic [ntsu_pkg::CFG_W-1:0]   resync_ms = ntsu_pkg::RESYNC_RESET;

   sync_cmd_type    pending_cmds[$];
   sync_result_type expected_results[$];
   int              errors = 0;
   int              transfers = 0;
   int              results_seen = 0;
   int              action_hits[6];

   // floor of the signed 48-bit difference in ms, mod 2^32
   function automatic logic [31:0] ms_between(logic [47:0] a, logic [47:0] b);
      longint d, q;
      d = longint'({16'd0, a}) - longint'({16'd0, b});
      if (d >= 0) q = d / 1000;
      else q = -((-d + 999) / 1000);
      return q[31:0];
   endfunction

   function automatic sync_result_type track_time(sync_cmd_type c);
      sync_result_type res;
      logic [31:0]     orig, base, n, r, x, mag;
      int unsigned     pos;
      bit              hit;
      res = '{default: '0};
      hit = 0;
      pos = 0;
      if (c.cmd == ntsu_pkg::CMD_RECORD) begin
         if (ring_cnt >= ntsu_pkg::RING_DEPTH) begin
            ring_head = (ring_tail + 1) % ntsu_pkg::RING_DEPTH;
            ring_cnt = ntsu_pkg::RING_DEPTH - 1;
         end
         ring_st[ring_tail] = c.stamp;
         ring_us[ring_tail] = c.now;
         ring_cnt++;
         ring_tail = (ring_tail + 1) % ntsu_pkg::RING_DEPTH;
      end else if (c.cmd == ntsu_pkg::CMD_RESPONSE) begin
         orig = c.stamp - c.delay - c.stay;
         pos = ring_head;
         for (int i = 0; i < ring_cnt; i++) begin
            if (ring_st[pos] > orig) begin
               ring_cnt -= i;
               ring_head = pos;
               break;
            end
            if (ring_st[pos] == orig) begin
               hit = 1;
               ring_cnt -= i + 1;
               ring_head = (pos + 1) % ntsu_pkg::RING_DEPTH;
               break;
            end
            pos = (pos + 1) % ntsu_pkg::RING_DEPTH;
         end
         if (hit) begin
            base = ring_st[pos] + (c.delay >> 1);
            res.match = 1'b1;
            if (est_ms == 0) begin
               est_ms = base;
               anchor_us = ring_us[pos];
               res.action = ntsu_pkg::ACT_FIRST;
            end else begin
               n = est_ms + ms_between(c.now, anchor_us);
               r = base + ms_between(c.now, ring_us[pos]);
               x = n - r;
               mag = x[31] ? -x : x;
               if (mag >= {16'd0, resync_ms}) begin
                  est_ms = base;
                  anchor_us = ring_us[pos];
                  res.action = ntsu_pkg::ACT_RESYNC;
               end else if (mag > {16'd0, nudge_ms}) begin
                  if (n > r) begin
                     est_ms--;
                     res.action = ntsu_pkg::ACT_DOWN;
                  end else begin
                     est_ms++;
                     res.action = ntsu_pkg::ACT_UP;
                  end
               end else begin
                  res.action = ntsu_pkg::ACT_IN_BAND;
               end
            end
         end
      end else if (c.cmd == ntsu_pkg::CMD_CLEAR) begin
         est_ms = 0;
         ring_head = 0;
         ring_tail = 0;
         ring_cnt = 0;
      end
      if (c.cmd == ntsu_pkg::CMD_READ && est_ms != 0)
         res.net_time = est_ms + ms_between(c.now, anchor_us);
      else if (c.cmd == ntsu_pkg::CMD_READ) res.net_time = '0;
      else res.net_time = est_ms;
      res.synced = (est_ms != 0);
      res.fill = ring_cnt[ntsu_pkg::FILL_W-1:0];
      return res;
   endfunction

   // driver: bursts with random gaps
   int  burst_left = 0;
   int  gap_left = 0;
   bit  sender_paused = 0;
   sync_cmd_type drv_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         ring_head = 0;
         ring_tail = 0;
         ring_cnt = 0;
         est_ms = 0;
         anchor_us = 0;
      end else begin
         if (req_valid && req_ready) begin
            drv_item = '{req_cmd, req_net_stamp, req_path_delay, req_stay_time,
                         req_local_time_us};
            expected_results.push_back(track_time(drv_item));
            transfers++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !sender_paused) begin
               drv_item = pending_cmds.pop_front();
               req_cmd <= drv_item.cmd;
               req_net_stamp <= drv_item.stamp;
               req_path_delay <= drv_item.delay;
               req_stay_time <= drv_item.stay;
               req_local_time_us <= drv_item.now;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_cnt = 0;

   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_cnt <= 600;
         hold_done <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("ERROR result %0d: %s got %0h expected %0h", results_seen, field, got, want);
      errors++;
   endtask

   // monitor and scoreboard
   int stall_mode = 0;
   int cycle_cnt = 0;
   sync_result_type want;

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report("unexpected transfer", 64'd1, 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_network_time !== want.net_time)
               report("network_time", rsp_network_time, want.net_time);
            if (rsp_match_found !== want.match) report("match_found", rsp_match_found, want.match);
            if (rsp_action !== want.action) report("action", rsp_action, want.action);
            if (rsp_synced !== want.synced) report("synced", rsp_synced, want.synced);
            if (rsp_ring_fill !== want.fill) report("ring_fill", rsp_ring_fill, want.fill);
            if (want.action <= ntsu_pkg::ACT_RESYNC) action_hits[want.action]++;
         end
         results_seen++;
      end
      if (hold_cnt > 0) rsp_ready <= 1'b0;
      else if (stall_mode == 0) rsp_ready <= 1'b1;
      else if (stall_mode == 1) rsp_ready <= $urandom_range(0, 1);
      else rsp_ready <= (cycle_cnt % 4 == 0);
   end

   // stimulus generation
   logic [ntsu_pkg::LOCAL_W-1:0] gen_now;
   logic [ntsu_pkg::STAMP_W-1:0] gen_off;
   logic [ntsu_pkg::STAMP_W-1:0] shadow_st[$];
   logic [ntsu_pkg::LOCAL_W-1:0] shadow_us[$];

   task automatic push(logic [ntsu_pkg::CMD_W-1:0] c, logic [31:0] s, logic [31:0] d,
                       logic [31:0] st, logic [47:0] t);
      sync_cmd_type it;
      it = '{c, s, d, st, t};
      pending_cmds.push_back(it);
   endtask

   task automatic write_reg(logic [ntsu_pkg::CSR_IDX_W-1:0] idx,
                            logic [ntsu_pkg::CFG_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= v;
      if (idx == ntsu_pkg::CSR_NUDGE) nudge_ms = v;
      else resync_ms = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_item();
      int                         pick, j;
      logic [31:0]                s, d, st, rnd;
      logic [ntsu_pkg::CMD_W-1:0] nc;
      pick = $urandom_range(0, 99);
      gen_now += $urandom_range(1, 3000000);
      if ($urandom_range(0, 19) == 0) gen_now -= $urandom_range(0, 8000000);
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: gen_off += $urandom_range(0, 120);
            1: gen_off -= $urandom_range(0, 120);
            2: gen_off += $urandom_range(100, 600);
            default: gen_off -= $urandom_range(100, 600);
         endcase
      end
      if (pick < 45) begin
         s = 32'(gen_now / 1000) + gen_off;
         shadow_st.push_back(s);
         shadow_us.push_back(gen_now);
         if (shadow_st.size() > 48) begin
            void'(shadow_st.pop_front());
            void'(shadow_us.pop_front());
         end
         push(ntsu_pkg::CMD_RECORD, s, $urandom, $urandom, gen_now);
      end else if (pick < 80) begin
         d = $urandom_range(0, 400);
         st = $urandom_range(0, 1000);
         if (shadow_st.size() > 0 && $urandom_range(0, 4) != 0) begin
            j = shadow_st.size() - 1 - $urandom_range(0, (shadow_st.size() > 8) ? 8 :
                                                        shadow_st.size() - 1);
            push(ntsu_pkg::CMD_RESPONSE, shadow_st[j] + d + st, d, st, gen_now);
         end else begin
            push(ntsu_pkg::CMD_RESPONSE, $urandom, d, st, gen_now);
         end
      end else if (pick < 92) begin
         push(ntsu_pkg::CMD_READ, $urandom, $urandom, $urandom, gen_now);
      end else if (pick < 95) begin
         shadow_st.delete();
         shadow_us.delete();
         push(ntsu_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, gen_now);
      end else begin
         // noise: every field fully random
         rnd = $urandom;
         nc = rnd[ntsu_pkg::CMD_W-1:0];
         push(nc, $urandom, $urandom, $urandom, 48'({$urandom, $urandom}));
      end
   endtask

   logic [ntsu_pkg::CFG_W-1:0] nudge_set[5]  = '{16'd0, 16'd65535, 16'd50, 16'd300, 16'd10};
   logic [ntsu_pkg::CFG_W-1:0] resync_set[5] =
      '{16'd0, 16'd65535, 16'd200, 16'd100, 16'd40000};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset thresholds
      push(ntsu_pkg::CMD_READ, 0, 0, 0, 48'd5000);                  // read while unsynced
      push(ntsu_pkg::CMD_RESPONSE, 32'd77, 0, 0, 48'd5000);         // empty ring
      push(ntsu_pkg::CMD_RECORD, 32'd1000, 0, 0, 48'd10000);
      push(ntsu_pkg::CMD_RECORD, 32'd2000, 0, 0, 48'd20000);
      push(ntsu_pkg::CMD_RESPONSE, 32'd1600, 32'd60, 32'd40, 48'd30000); // larger entry stops
      push(ntsu_pkg::CMD_RESPONSE, 32'd2100, 32'd50, 32'd50, 48'd30000); // first sync
      push(ntsu_pkg::CMD_READ, 0, 0, 0, 48'd90000);
      push(ntsu_pkg::CMD_READ, 0, 0, 0, 48'd1000);                  // now before anchor
      push(ntsu_pkg::CMD_RECORD, 32'd10, 0, 0, 48'd0);
      push(ntsu_pkg::CMD_RECORD, 32'd20, 0, 0, 48'd0);
      push(ntsu_pkg::CMD_RESPONSE, 32'd30, 0, 0, 48'd0);            // no hit, ring kept
      push(ntsu_pkg::CMD_CLEAR, '1, '1, '1, '1);
      push(ntsu_pkg::CMD_RECORD, 32'hFFFF_FF00, 0, 0, 48'd100);
      push(ntsu_pkg::CMD_RESPONSE, 32'h0000_0100, 32'h200, 0, 48'd200); // sync lands on zero
      push(ntsu_pkg::CMD_RECORD, 32'd1, 0, 0, 48'd1000000);
      push(ntsu_pkg::CMD_RESPONSE, 32'd1, 0, 0, 48'd1000000);       // estimate of one
      push(ntsu_pkg::CMD_RECORD, 32'd5, 0, 0, 48'd1200000);
      push(ntsu_pkg::CMD_RESPONSE, 32'd5, 0, 32'hFFFF_FFFB, 48'd1200000); // origin 10 passes entry 5, no hit
      push(ntsu_pkg::CMD_RECORD, '1, '1, '1, '1);
      push(ntsu_pkg::CMD_RESPONSE, '1, 0, 0, '1);
      push(ntsu_pkg::CMD_READ, '1, '1, '1, '1);
      push(ntsu_pkg::CMD_CLEAR, 0, 0, 0, 0);
      wait_drained();

      // run of records, then a deep walk and a full miss
      write_reg(ntsu_pkg::CSR_NUDGE, 16'd65535);
      write_reg(ntsu_pkg::CSR_RESYNC, 16'd65535);
      for (int i = 0; i < 8; i++)
         push(ntsu_pkg::CMD_RECORD, 32'(5000 + i), 0, 0, 48'(i * 1000));
      push(ntsu_pkg::CMD_RESPONSE, 32'd5006, 0, 0, 48'd5000000);
      push(ntsu_pkg::CMD_RESPONSE, 32'hFFFF_0000, 0, 0, 48'd5000000);
      push(ntsu_pkg::CMD_CLEAR, 0, 0, 0, 0);
      wait_drained();

      gen_now = 48'({$urandom, $urandom}) & 48'h0FFF_FFFF_FFFF;
      gen_off = $urandom;
      for (int p = 0; p < 5; p++) begin
         write_reg(ntsu_pkg::CSR_NUDGE, nudge_set[p]);
         write_reg(ntsu_pkg::CSR_RESYNC, resync_set[p]);
         if (p == 2) hold_go <= 1'b1;
         for (int k = 0; k < 22; k++) random_item();
         if (p == 3) begin
            // sender pauses until everything is back, then resumes
            while (pending_cmds.size() > 12) @(posedge clock);
            sender_paused = 1;
            while (req_valid || expected_results.size() != 0) @(posedge clock);
            sender_paused = 0;
         end
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("ERROR %0d results never arrived", expected_results.size());
         errors++;
      end
      $display("Run covered %0d transfers and %0d results: directed corner cases,",
               transfers, results_seen);
      $display("a deep ring walk and five random threshold sets with receiver stalls.");
      $display("Actions: first %0d, down %0d, up %0d, in band %0d, resync %0d.",
               action_hits[ntsu_pkg::ACT_FIRST], action_hits[ntsu_pkg::ACT_DOWN],
               action_hits[ntsu_pkg::ACT_UP], action_hits[ntsu_pkg::ACT_IN_BAND],
               action_hits[ntsu_pkg::ACT_RESYNC]);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("ERROR timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
